### sv/sartrim_pkg.sv
// Shared types, widths and codes for the SAR trim closest-match search.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sartrim_pkg;

  localparam int CODE_BITS  = 6;
  localparam int POS_W      = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
  localparam int OUT_CODE_W = 6;
  localparam int THR_W      = 16;
  localparam int IDX_W      = 1;

  // Register indexes of the config port
  localparam logic [IDX_W-1:0] REG_TARGET    = 1'd0;
  localparam logic [IDX_W-1:0] REG_INIT_DIFF = 1'd1;

  // Item kind, carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_MEAS  = 1'b1;

  typedef enum logic [1:0] {
    ST_MEASURE = 2'd0,
    ST_DONE    = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  typedef struct packed {
    logic             cmd;
    logic [THR_W-1:0] measured_threshold;
    logic             noisy;
  } item_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_CODE_W-1:0] code;
    logic [THR_W-1:0]      best_difference;
  } res_t;

  // Low bits of a trim code, zero-extended when the code is narrower
  function automatic logic [OUT_CODE_W-1:0] out_code(input logic [CODE_BITS-1:0] c);
    logic [CODE_BITS+OUT_CODE_W-1:0] wide;
    wide = {{OUT_CODE_W{1'b0}}, c};
    return wide[OUT_CODE_W-1:0];
  endfunction

endpackage

### sv/sartrim_cfg_regs.sv
// Configuration registers: target threshold and starting best difference.
// Depends on sartrim_pkg.
`timescale 1ns / 1ps

module sartrim_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [sartrim_pkg::IDX_W-1:0]  wr_index,
  input  logic [sartrim_pkg::THR_W-1:0]  wr_data,
  output logic [sartrim_pkg::THR_W-1:0]  target,
  output logic [sartrim_pkg::THR_W-1:0]  init_diff
);

  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      init_diff <= '1;
    end else if (wr_en) begin
      case (wr_index)
        sartrim_pkg::REG_TARGET:    target    <= wr_data;
        sartrim_pkg::REG_INIT_DIFF: init_diff <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/sartrim_search.sv
// Search state and its single-pass update: one item in, one result out.
// Depends on sartrim_pkg.
`timescale 1ns / 1ps

module sartrim_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  sartrim_pkg::item_t            item,
  input  logic [sartrim_pkg::THR_W-1:0] target,
  input  logic [sartrim_pkg::THR_W-1:0] init_diff,
  output sartrim_pkg::res_t             res
);

  localparam int CB = sartrim_pkg::CODE_BITS;
  localparam int PW = sartrim_pkg::POS_W;
  localparam int TW = sartrim_pkg::THR_W;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_ZERO   = 2'd2
  } phase_t;

  phase_t        phase, phase_next;
  logic [CB-1:0] trial_code, trial_code_next;
  logic [PW-1:0] bit_position, bit_position_next;
  logic [CB-1:0] best_code, best_code_next;
  logic [TW-1:0] best_diff, best_diff_next;

  logic [TW-1:0] diff;
  logic          below;
  logic          take;
  logic [CB-1:0] cleared;
  logic [PW-1:0] pos_dec;

  assign below   = item.measured_threshold < target;
  assign diff    = below ? (target - item.measured_threshold)
                         : (item.measured_threshold - target);
  assign take    = !item.noisy && (diff < best_diff);
  assign cleared = (item.noisy || below)
                 ? (trial_code & ~(CB'(1) << bit_position)) : trial_code;
  assign pos_dec = bit_position - PW'(1);

  always_comb begin
    phase_next        = phase;
    trial_code_next   = trial_code;
    bit_position_next = bit_position;
    best_code_next    = best_code;
    best_diff_next    = best_diff;
    res.status        = sartrim_pkg::ST_REJECT;
    res.code          = sartrim_pkg::out_code(best_code);

    if (item.cmd == sartrim_pkg::CMD_START) begin
      bit_position_next = PW'(CB - 1);
      trial_code_next   = CB'(1) << (CB - 1);
      best_code_next    = CB'(1) << (CB - 1);
      best_diff_next    = init_diff;
      phase_next        = PH_SEARCH;
      res.status        = sartrim_pkg::ST_MEASURE;
      res.code          = sartrim_pkg::out_code(CB'(1) << (CB - 1));
    end else begin
      case (phase)
        PH_SEARCH: begin
          if (take) begin
            best_diff_next = diff;
            best_code_next = trial_code;
          end
          if (bit_position != '0) begin
            bit_position_next = pos_dec;
            trial_code_next   = cleared | (CB'(1) << pos_dec);
            res.status        = sartrim_pkg::ST_MEASURE;
            res.code          = sartrim_pkg::out_code(cleared | (CB'(1) << pos_dec));
          end else if (cleared == '0) begin
            // all bits dropped: measure code zero once more
            trial_code_next = '0;
            phase_next      = PH_ZERO;
            res.status      = sartrim_pkg::ST_MEASURE;
            res.code        = '0;
          end else begin
            trial_code_next = cleared;
            phase_next      = PH_IDLE;
            res.status      = sartrim_pkg::ST_DONE;
            res.code        = sartrim_pkg::out_code(best_code_next);
          end
        end
        PH_ZERO: begin
          if (take) begin
            best_diff_next = diff;
            best_code_next = '0;
          end
          phase_next = PH_IDLE;
          res.status = sartrim_pkg::ST_DONE;
          res.code   = sartrim_pkg::out_code(best_code_next);
        end
        default: ;
      endcase
    end
    res.best_difference = best_diff_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      trial_code   <= '0;
      bit_position <= '0;
      best_code    <= '0;
      best_diff    <= '1;
    end else if (step) begin
      phase        <= phase_next;
      trial_code   <= trial_code_next;
      bit_position <= bit_position_next;
      best_code    <= best_code_next;
      best_diff    <= best_diff_next;
    end
  end

endmodule

### sv/sar_trim_search_closest_match_core.sv
// Top level of the SAR trim closest-match search: input register, search
// update, result register. Depends on sartrim_pkg, sartrim_cfg_regs, sartrim_search.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser=cmd, tdata=threshold,noisy
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser=status, tdata=code,best_diff
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One word per cycle while m_axis does not stall; a word taken on s_axis
// passes the input register, then the result register, to reach m_axis.
// Synchronous reset clears the search state to idle and empties both stages.
// A stall on m_axis holds the result register and then the input register;
// s_axis_tready drops only when both are full and m_axis_tready is low.
// cfg_ready is always high.
`timescale 1ns / 1ps

module sar_trim_search_closest_match_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // [15:0] measured_threshold, [16] noisy, rest 0
  input  logic                                s_axis_tuser,  // [0] cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,  // [5:0] code, [21:6] best_difference, rest 0
  output logic [1:0]                          m_axis_tuser,  // [1:0] status
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sartrim_pkg::IDX_W-1:0]       cfg_index,
  input  logic [sartrim_pkg::THR_W-1:0]       cfg_data
);

  localparam int TW = sartrim_pkg::THR_W;
  localparam int OW = sartrim_pkg::OUT_CODE_W;

  logic                          s1_valid;
  sartrim_pkg::item_t            s1_item;
  logic                          s1_adv;
  logic                          out_valid;
  sartrim_pkg::res_t             out_res;
  sartrim_pkg::res_t             res;
  logic [TW-1:0]                 target;
  logic [TW-1:0]                 init_diff;

  assign cfg_ready     = 1'b1;
  assign s1_adv        = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_adv;

  sartrim_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .target   (target),
    .init_diff(init_diff)
  );

  sartrim_search u_search (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_valid && s1_adv),
    .item     (s1_item),
    .target   (target),
    .init_diff(init_diff),
    .res      (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item.cmd                <= s_axis_tuser;
      s1_item.measured_threshold <= s_axis_tdata[TW-1:0];
      s1_item.noisy              <= s_axis_tdata[TW];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {{(24 - OW - TW){1'b0}}, out_res.best_difference, out_res.code};

`ifndef SYNTHESIS
  a_hold_s1 : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("input register lost or changed a stalled word");

  a_start_measure : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_adv && s1_item.cmd == sartrim_pkg::CMD_START
    |=> m_axis_tvalid && m_axis_tuser == sartrim_pkg::ST_MEASURE)
    else $error("start command did not ask for a measurement");

  a_reject_only_meas : assert property (@(posedge clk) disable iff (rst)
    s1_valid && res.status == sartrim_pkg::ST_REJECT |-> s1_item.cmd == sartrim_pkg::CMD_MEAS)
    else $error("start command rejected");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s1_valid))
    else $error("result appeared without a word in the input register");
`endif

endmodule

### test/sar_trim_search_closest_match_core_test.sv
// Self-checking testbench for the SAR trim closest-match search core.
// Drives the s_axis and cfg ports, predicts every m_axis word; needs sartrim_pkg.
`timescale 1ns / 1ps

module sar_trim_search_closest_match_core_test;

  typedef enum logic [1:0] {
    SRCH_IDLE = 2'd0,
    SRCH_RUN  = 2'd1,
    SRCH_ZERO = 2'd2
  } srch_phase_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [23:0]                     s_axis_tdata;  // [15:0] measured_threshold, [16] noisy, rest 0
  logic                            s_axis_tuser;  // [0] cmd
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [23:0]                     m_axis_tdata;  // [5:0] code, [21:6] best_difference, rest 0
  logic [1:0]                      m_axis_tuser;  // [1:0] status
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [sartrim_pkg::IDX_W-1:0]   cfg_index;
  logic [sartrim_pkg::THR_W-1:0]   cfg_data;

  sar_trim_search_closest_match_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // stimulus and expectations
  sartrim_pkg::item_t pending_words[$];
  sartrim_pkg::res_t  trim_replies[$];
  sartrim_pkg::item_t drv_word;
  logic               word_taken;
  int                 tx_idle;
  int                 rx_idle;
  int                 errs;
  logic [15:0]        gen_target;

  // shadow of the search
  logic [sartrim_pkg::THR_W-1:0]     sh_target;
  logic [sartrim_pkg::THR_W-1:0]     sh_init_diff;
  logic [sartrim_pkg::CODE_BITS-1:0] sh_trial;
  int                                sh_pos;
  logic [sartrim_pkg::CODE_BITS-1:0] sh_best_code;
  logic [sartrim_pkg::THR_W-1:0]     sh_best_diff;
  srch_phase_t                       sh_phase;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_idle       = 32;
    rx_idle       = 87;
    errs          = 0;
    gen_target    = 16'd0;
  end

  // Track the closest non-noisy trial
  task automatic weigh_trial(input sartrim_pkg::item_t it,
                             input logic [sartrim_pkg::CODE_BITS-1:0] c);
    logic [sartrim_pkg::THR_W-1:0] gap;
    if (!it.noisy) begin
      gap = (it.measured_threshold >= sh_target) ? it.measured_threshold - sh_target
                                                 : sh_target - it.measured_threshold;
      if (gap < sh_best_diff) begin
        sh_best_diff = gap;
        sh_best_code = c;
      end
    end
  endtask

  task automatic search_predict(input sartrim_pkg::item_t it, output sartrim_pkg::res_t r);
    logic [sartrim_pkg::CODE_BITS-1:0] bitm;
    r.status = sartrim_pkg::ST_REJECT;
    r.code   = sartrim_pkg::OUT_CODE_W'(sh_best_code);
    if (it.cmd == sartrim_pkg::CMD_START) begin
      sh_pos   = sartrim_pkg::CODE_BITS - 1;
      sh_trial = '0;
      sh_trial[sartrim_pkg::CODE_BITS-1] = 1'b1;
      sh_best_code = sh_trial;
      sh_best_diff = sh_init_diff;
      sh_phase     = SRCH_RUN;
      r.status = sartrim_pkg::ST_MEASURE;
      r.code   = sartrim_pkg::OUT_CODE_W'(sh_trial);
    end else if (sh_phase == SRCH_RUN) begin
      bitm = '0;
      bitm[sh_pos] = 1'b1;
      weigh_trial(it, sh_trial);
      if (it.noisy || it.measured_threshold < sh_target) sh_trial = sh_trial & ~bitm;
      if (sh_pos > 0) begin
        sh_pos = sh_pos - 1;
        sh_trial[sh_pos] = 1'b1;
        r.status = sartrim_pkg::ST_MEASURE;
        r.code   = sartrim_pkg::OUT_CODE_W'(sh_trial);
      end else if (sh_trial == '0) begin
        // every bit dropped: code zero gets one more look
        sh_phase = SRCH_ZERO;
        r.status = sartrim_pkg::ST_MEASURE;
        r.code   = '0;
      end else begin
        sh_phase = SRCH_IDLE;
        r.status = sartrim_pkg::ST_DONE;
        r.code   = sartrim_pkg::OUT_CODE_W'(sh_best_code);
      end
    end else if (sh_phase == SRCH_ZERO) begin
      weigh_trial(it, '0);
      sh_phase = SRCH_IDLE;
      r.status = sartrim_pkg::ST_DONE;
      r.code   = sartrim_pkg::OUT_CODE_W'(sh_best_code);
    end
    r.best_difference = sh_best_diff;
  endtask

  // Shadow update, result check and input prediction, all on the rising edge
  always @(posedge clk) begin
    sartrim_pkg::res_t want;
    sartrim_pkg::res_t got;
    if (rst) begin
      word_taken   <= 1'b0;
      sh_target    = '0;
      sh_init_diff = '1;
      sh_trial     = '0;
      sh_pos       = 0;
      sh_best_code = '0;
      sh_best_diff = '1;
      sh_phase     = SRCH_IDLE;
    end else begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sartrim_pkg::REG_TARGET:    sh_target    = cfg_data;
          sartrim_pkg::REG_INIT_DIFF: sh_init_diff = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (trim_replies.size() == 0) begin
          $display("%0t: unexpected word status=%0d code=%0d diff=%0d", $time,
                   m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6]);
          errs++;
        end else begin
          want = trim_replies.pop_front();
          got.status          = sartrim_pkg::status_t'(m_axis_tuser);
          got.code            = m_axis_tdata[5:0];
          got.best_difference = m_axis_tdata[21:6];
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
            errs++;
          end
          if (got.code !== want.code) begin
            $display("%0t: code expected %0d actual %0d", $time, want.code, got.code);
            errs++;
          end
          if (got.best_difference !== want.best_difference) begin
            $display("%0t: best_difference expected %0d actual %0d", $time,
                     want.best_difference, got.best_difference);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        drv_word.cmd                = s_axis_tuser;
        drv_word.measured_threshold = s_axis_tdata[15:0];
        drv_word.noisy              = s_axis_tdata[16];
        search_predict(drv_word, want);
        trim_replies = {trim_replies, want};
      end
    end
  end

  // Input driver: next word goes out once the current one is taken
  always @(negedge clk) begin
    sartrim_pkg::item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle) begin
        nxt = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.cmd;
        s_axis_tdata  <= {7'd0, nxt.noisy, nxt.measured_threshold};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic add_word(input logic cmd, input logic [15:0] thr, input logic nz);
    sartrim_pkg::item_t w;
    w.cmd                = cmd;
    w.measured_threshold = thr;
    w.noisy              = nz;
    pending_words = {pending_words, w};
  endtask

  task automatic cfg_write(input logic [sartrim_pkg::IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == sartrim_pkg::REG_TARGET) gen_target = val;
  endtask

  // Idle means nothing queued, nothing on the bus and nothing outstanding
  task automatic wait_drained();
    @(negedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid || trim_replies.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // low: the trial bit must drop (noisy or below target)
  task automatic pick_meas(input bit low, output logic [15:0] thr, output logic nz);
    int v;
    int sel;
    sel = $urandom_range(9);
    nz  = ($urandom_range(7) == 0);
    if (low) begin
      if (gen_target == 16'd0 || $urandom_range(5) == 0) begin
        thr = 16'($urandom);
        nz  = 1'b1;
      end else begin
        thr = 16'($urandom_range(gen_target - 1, 0));
      end
    end else if (sel < 5) begin
      v = int'(gen_target) + int'($urandom_range(128)) - 64;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      thr = v[15:0];
    end else if (sel < 8) begin
      thr = 16'($urandom);
    end else if (sel == 8) begin
      thr = 16'h0000;
    end else begin
      thr = 16'hFFFF;
    end
  endtask

  task automatic fill_random(input int n);
    int          cnt;
    int          stop_at;
    int          k;
    bit          low;
    logic [15:0] thr;
    logic        nz;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        low = ($urandom_range(99) < 20);
        // a few searches are cut short and restarted by the next start
        stop_at = ($urandom_range(9) == 0) ? int'($urandom_range(5)) : sartrim_pkg::CODE_BITS;
        add_word(sartrim_pkg::CMD_START, 16'($urandom), 1'($urandom_range(1)));
        cnt++;
        for (k = 0; k < stop_at; k++) begin
          pick_meas(low, thr, nz);
          add_word(sartrim_pkg::CMD_MEAS, thr, nz);
          cnt++;
        end
        if (stop_at == sartrim_pkg::CODE_BITS && (low || $urandom_range(3) == 0)) begin
          pick_meas(1'($urandom_range(1)), thr, nz);
          add_word(sartrim_pkg::CMD_MEAS, thr, nz);
          cnt++;
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          add_word(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    int ph;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: target 0, so nothing is ever below target
    add_word(sartrim_pkg::CMD_MEAS, 16'h1234, 1'b0);  // measurement before any start
    add_word(sartrim_pkg::CMD_START, 16'h0000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h0000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'hFFFF, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h0005, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'hFFFF, 1'b1);
    add_word(sartrim_pkg::CMD_MEAS, 16'h8000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h0001, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h4321, 1'b1);  // after done: rejected
    wait_drained();

    cfg_write(sartrim_pkg::REG_TARGET, 16'h8000);
    cfg_write(sartrim_pkg::REG_INIT_DIFF, 16'hFFFF);
    @(posedge clk);
    // all trials drop, then the zero check
    add_word(sartrim_pkg::CMD_START, 16'hFFFF, 1'b1);
    add_word(sartrim_pkg::CMD_MEAS, 16'h0000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h7FFF, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h8000, 1'b1);
    add_word(sartrim_pkg::CMD_MEAS, 16'h1000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h7FFE, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h0000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h8001, 1'b0);
    // restart mid-search, then exact hit and a tie
    add_word(sartrim_pkg::CMD_START, 16'h0000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h9000, 1'b0);
    add_word(sartrim_pkg::CMD_START, 16'h0000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h8010, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h7FF0, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h8000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h8000, 1'b0);
    add_word(sartrim_pkg::CMD_MEAS, 16'h7FFF, 1'b1);
    add_word(sartrim_pkg::CMD_MEAS, 16'hFFFF, 1'b0);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(sartrim_pkg::REG_TARGET, 16'($urandom));
          cfg_write(sartrim_pkg::REG_INIT_DIFF, 16'hFFFF);
        end
        1: begin
          cfg_write(sartrim_pkg::REG_TARGET, 16'hFFFF);
          cfg_write(sartrim_pkg::REG_INIT_DIFF, 16'($urandom));
        end
        2: begin
          cfg_write(sartrim_pkg::REG_TARGET, 16'h0000);
          cfg_write(sartrim_pkg::REG_INIT_DIFF, 16'h0000);
        end
        4: begin
          cfg_write(sartrim_pkg::REG_TARGET, 16'h8000);
          cfg_write(sartrim_pkg::REG_INIT_DIFF, 16'h00FF);
        end
        default: begin
          cfg_write(sartrim_pkg::REG_TARGET, 16'($urandom));
          cfg_write(sartrim_pkg::REG_INIT_DIFF, 16'($urandom));
        end
      endcase
      if (ph < 2) begin
        tx_idle = 32;
        rx_idle = 87;
      end else if (ph < 4) begin
        tx_idle = 87;
        rx_idle = 32;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      @(posedge clk);
      fill_random(240);
      wait_drained();
    end

    if (trim_replies.size() != 0) errs++;
    if (errs == 0) begin
      $display("sar_trim_search_closest_match_core verification clean");
    end else begin
      $display("sar_trim_search_closest_match_core verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("sar_trim_search_closest_match_core verification failed");
    $finish;
  end

endmodule

### sim.f
sv/sartrim_pkg.sv
sv/sartrim_cfg_regs.sv
sv/sartrim_search.sv
sv/sar_trim_search_closest_match_core.sv
test/sar_trim_search_closest_match_core_test.sv
